>>> rtl/core/rssi_jamming_detector_macros.svh
// ----------------------------------------------------------------------------
// rssi jamming detector assertion macros
// concurrent assertion wrappers used by the checker file
// ----------------------------------------------------------------------------
`ifndef RSSI_JAMMING_DETECTOR_MACROS_SVH
`define RSSI_JAMMING_DETECTOR_MACROS_SVH

// property checked only outside reset
`define RJD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define RJD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/rjd_pkg.sv
// ----------------------------------------------------------------------------
// rjd_pkg
// widths, codes and shared types of the rssi jamming detector
// ----------------------------------------------------------------------------
package rjd_pkg;

   localparam int RSSI_W      = 9;
   localparam int STATUS_W    = 2;
   localparam int DBM_W       = 8;
   localparam int BAR_W       = 7;
   localparam int WARM_W      = 6;
   localparam int MARGIN_W    = 8;
   localparam int RUN_W       = 8;
   localparam int SUM_W       = 16;
   localparam int BASE_W      = 14;
   localparam int FRAC_W      = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   // register reset values
   localparam logic [WARM_W-1:0]   WARMUP_RESET = 6'd24;
   localparam logic [MARGIN_W-1:0] LOUD_RESET   = 8'd30;
   localparam logic [MARGIN_W-1:0] NOISE_RESET  = 8'd16;
   localparam logic [RUN_W-1:0]    RUN_RESET    = 8'd20;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_CALIBRATING = 2'd0,
      STATUS_QUIET       = 2'd1,
      STATUS_NOISE       = 2'd2,
      STATUS_JAMMING     = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WARMUP_SAMPLES = 2'd0,
      CSR_LOUD_MARGIN    = 2'd1,
      CSR_NOISE_MARGIN   = 2'd2,
      CSR_JAM_RUN_LIMIT  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [WARM_W-1:0]   warmup_samples;
      logic [MARGIN_W-1:0] loud_margin;
      logic [MARGIN_W-1:0] noise_margin;
      logic [RUN_W-1:0]    jam_run_limit;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic decide;
      logic finish;
      logic load_out;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic calib;
      logic div_busy;
   } dp_stat_type;

endpackage

>>> rtl/core/rjd_if.sv
// ----------------------------------------------------------------------------
// rjd_if
// valid/ready channels of the rssi jamming detector
// ----------------------------------------------------------------------------
interface rjd_req_if;
   import rjd_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [RSSI_W-1:0] rssi_half_db;
   logic                     restart;

   modport source (output valid, output rssi_half_db, output restart, input ready);
   modport sink (input valid, input rssi_half_db, input restart, output ready);
   modport monitor (input valid, input ready, input rssi_half_db, input restart);
endinterface

interface rjd_rsp_if;
   import rjd_pkg::*;

   logic                    valid;
   logic                    ready;
   status_type              status;
   logic signed [DBM_W-1:0] rssi_dbm;
   logic signed [DBM_W-1:0] baseline_dbm;
   logic [BAR_W-1:0]        bar_percent;

   modport source (output valid, output status, output rssi_dbm, output baseline_dbm,
                   output bar_percent, input ready);
   modport sink (input valid, input status, input rssi_dbm, input baseline_dbm,
                 input bar_percent, output ready);
   modport monitor (input valid, input ready, input status, input rssi_dbm,
                    input baseline_dbm, input bar_percent);
endinterface

>>> rtl/core/rjd_divider.sv
// ----------------------------------------------------------------------------
// rjd_divider
// restoring divider, one quotient bit per cycle, for the baseline mean
// ----------------------------------------------------------------------------
module rjd_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [rjd_pkg::SUM_W-1:0] dividend,
   input  logic [rjd_pkg::WARM_W-1:0]       divisor,
   output logic                             busy,
   output logic signed [rjd_pkg::BASE_W-1:0] quotient
);
   import rjd_pkg::*;

   localparam int DIV_BITS    = SUM_W + FRAC_W;
   localparam int DIV_COUNT_W = $clog2(DIV_BITS + 1);

   logic [DIV_COUNT_W-1:0] count_ff, count_in;
   logic [DIV_BITS-1:0]    work_ff, work_in;
   logic [WARM_W-1:0]      rem_ff, rem_in;
   logic [WARM_W-1:0]      divisor_ff, divisor_in;
   logic                   neg_ff, neg_in;

   logic [SUM_W-1:0]  magnitude;
   logic [WARM_W:0]   trial;
   logic              fits;
   logic [BASE_W-1:0] q_mag;

   assign magnitude = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
   assign trial     = {rem_ff, work_ff[DIV_BITS-1]};
   assign fits      = trial >= {1'b0, divisor_ff};
   assign busy      = count_ff != '0;
   assign q_mag     = work_ff[BASE_W-1:0];
   assign quotient  = neg_ff ? $signed(BASE_W'(-q_mag)) : $signed(q_mag);

   always_comb begin
      count_in   = count_ff;
      work_in    = work_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      neg_in     = neg_ff;
      if (start) begin
         count_in   = DIV_COUNT_W'(DIV_BITS);
         work_in    = {magnitude, {FRAC_W{1'b0}}};
         rem_in     = '0;
         divisor_in = divisor;
         neg_in     = dividend[SUM_W-1];
      end else if (busy) begin
         count_in = count_ff - 1'b1;
         rem_in   = fits ? WARM_W'(trial - {1'b0, divisor_ff}) : trial[WARM_W-1:0];
         work_in  = {work_ff[DIV_BITS-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      neg_ff     <= neg_in;
   end

endmodule

>>> rtl/core/rjd_datapath.sv
// ----------------------------------------------------------------------------
// rjd_datapath
// calibration state, detection compare and result formatting
// ----------------------------------------------------------------------------
module rjd_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  rjd_pkg::dp_cmd_type               cmd,
   output rjd_pkg::dp_stat_type              stat,
   input  rjd_pkg::cfg_type                  cfg,
   input  logic signed [rjd_pkg::RSSI_W-1:0] req_rssi_half_db,
   input  logic                              req_restart,
   output rjd_pkg::status_type               rsp_status,
   output logic signed [rjd_pkg::DBM_W-1:0]  rsp_rssi_dbm,
   output logic signed [rjd_pkg::DBM_W-1:0]  rsp_baseline_dbm,
   output logic [rjd_pkg::BAR_W-1:0]         rsp_bar_percent
);
   import rjd_pkg::*;

   localparam int DIFF_W = BASE_W + 1;
   localparam int XE_W   = RSSI_W + 1;
   localparam int N_W    = XE_W + 3;
   localparam logic signed [XE_W-1:0] BAR_OFFSET = 10'sd240;
   localparam logic signed [N_W-1:0]  BAR_LOW_N  = 13'sd16;
   localparam logic [XE_W-1:0]        BAR_MAX    = 10'd100;
   localparam logic [BAR_W-1:0]       BAR_MIN    = 7'd2;

   // captured transaction
   logic signed [RSSI_W-1:0] x_ff;
   logic                     restart_ff;

   // detector state
   logic [WARM_W-1:0]        warm_count_ff, warm_count_in;
   logic signed [SUM_W-1:0]  warm_sum_ff, warm_sum_in;
   logic signed [BASE_W-1:0] baseline_ff, baseline_in;
   logic [RUN_W-1:0]         loud_run_ff, loud_run_in;
   status_type               status_ff, status_in;

   // result register
   status_type              out_status_ff;
   logic signed [DBM_W-1:0] out_rssi_ff;
   logic signed [DBM_W-1:0] out_base_ff;
   logic [BAR_W-1:0]        out_bar_ff;

   logic [WARM_W-1:0]        eff_count;
   logic signed [SUM_W-1:0]  eff_sum;
   logic signed [BASE_W-1:0] eff_base;
   logic [RUN_W-1:0]         eff_run;
   logic                     calib;
   logic signed [SUM_W-1:0]  new_sum;
   logic [WARM_W-1:0]        new_count;
   logic signed [DIFF_W-1:0] diff;
   logic signed [DIFF_W-1:0] loud_thr, noise_thr;
   logic                     loud;
   logic [RUN_W-1:0]         run_next;
   status_type               detect_status;
   logic                     div_busy;
   logic signed [BASE_W-1:0] quotient;

   logic signed [RSSI_W-1:0] x_round;
   logic signed [BASE_W-1:0] b_round;
   logic signed [XE_W-1:0]   xe;
   logic signed [N_W-1:0]    n;
   logic [XE_W-1:0]          bar_q;
   logic [BAR_W-1:0]         bar;

   // restart clears state before the sample is used
   assign eff_count = restart_ff ? '0 : warm_count_ff;
   assign eff_sum   = restart_ff ? '0 : warm_sum_ff;
   assign eff_base  = restart_ff ? '0 : baseline_ff;
   assign eff_run   = restart_ff ? '0 : loud_run_ff;
   assign calib     = eff_count < cfg.warmup_samples;

   assign new_sum   = eff_sum + SUM_W'(x_ff);
   assign new_count = eff_count + 1'b1;

   // sample scaled to the baseline's fraction bits, sign kept
   assign diff      = DIFF_W'($signed({x_ff, {FRAC_W{1'b0}}})) - DIFF_W'(eff_base);
   assign loud_thr  = $signed(DIFF_W'({cfg.loud_margin, {FRAC_W{1'b0}}}));
   assign noise_thr = $signed(DIFF_W'({cfg.noise_margin, {FRAC_W{1'b0}}}));
   assign loud      = diff > loud_thr;
   assign run_next  = !loud ? '0 : (&eff_run) ? eff_run : eff_run + 1'b1;

   always_comb begin
      if (run_next > cfg.jam_run_limit) begin
         detect_status = STATUS_JAMMING;
      end else if (diff > noise_thr) begin
         detect_status = STATUS_NOISE;
      end else begin
         detect_status = STATUS_QUIET;
      end
   end

   rjd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.decide && calib),
      .dividend (new_sum),
      .divisor  (new_count),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign stat.calib    = calib;
   assign stat.div_busy = div_busy;

   always_comb begin
      warm_count_in = warm_count_ff;
      warm_sum_in   = warm_sum_ff;
      baseline_in   = baseline_ff;
      loud_run_in   = loud_run_ff;
      status_in     = status_ff;
      if (cmd.decide) begin
         baseline_in = eff_base;
         if (calib) begin
            warm_count_in = new_count;
            warm_sum_in   = new_sum;
            loud_run_in   = '0;
            status_in     = STATUS_CALIBRATING;
         end else begin
            warm_count_in = eff_count;
            warm_sum_in   = eff_sum;
            loud_run_in   = run_next;
            status_in     = detect_status;
         end
      end else if (cmd.finish) begin
         baseline_in = quotient;
      end
   end

   // truncating divisions toward zero
   assign x_round = x_ff + RSSI_W'(x_ff[RSSI_W-1]);
   assign b_round = baseline_ff + (baseline_ff[BASE_W-1] ? BASE_W'(31) : BASE_W'(0));

   // bar: (x + 240) * 5 / 8, clamped 2..100
   assign xe    = XE_W'(x_ff) + BAR_OFFSET;
   assign n     = (N_W'(xe) <<< 2) + N_W'(xe);
   assign bar_q = n[N_W-1:3];
   always_comb begin
      if (n < BAR_LOW_N) begin
         bar = BAR_MIN;
      end else if (bar_q > BAR_MAX) begin
         bar = BAR_MAX[BAR_W-1:0];
      end else begin
         bar = bar_q[BAR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         warm_count_ff <= '0;
         warm_sum_ff   <= '0;
         baseline_ff   <= '0;
         loud_run_ff   <= '0;
      end else begin
         warm_count_ff <= warm_count_in;
         warm_sum_ff   <= warm_sum_in;
         baseline_ff   <= baseline_in;
         loud_run_ff   <= loud_run_in;
      end
      status_ff <= status_in;
      if (cmd.capture) begin
         x_ff       <= req_rssi_half_db;
         restart_ff <= req_restart;
      end
      if (cmd.load_out) begin
         out_status_ff <= status_ff;
         out_rssi_ff   <= x_round[RSSI_W-1:1];
         out_base_ff   <= b_round[DBM_W+4:5];
         out_bar_ff    <= bar;
      end
   end

   assign rsp_status       = out_status_ff;
   assign rsp_rssi_dbm     = out_rssi_ff;
   assign rsp_baseline_dbm = out_base_ff;
   assign rsp_bar_percent  = out_bar_ff;

endmodule

>>> rtl/core/rjd_ctrl.sv
// ----------------------------------------------------------------------------
// rjd_ctrl
// sequencer for one transaction at a time and the result valid flag
// ----------------------------------------------------------------------------
module rjd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   input  rjd_pkg::dp_stat_type  stat,
   output rjd_pkg::dp_cmd_type   cmd
);
   import rjd_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DECIDE = 5'b00010,
      ST_DIVIDE = 5'b00100,
      ST_FINISH = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_ready = state_ff == ST_IDLE;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.capture  = req_ready && req_valid;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = stat.calib ? ST_DIVIDE : ST_EMIT;
         end
         ST_DIVIDE: begin
            if (!stat.div_busy) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_out ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/core/rssi_jamming_detector.sv
// ----------------------------------------------------------------------------
// rssi_jamming_detector
// Takes one RSSI sample per req transaction (half-dBm, signed) and returns
// one rsp transaction. After reset or a transaction with restart set, the
// first warmup_samples samples are averaged into a baseline (4 fraction bits)
// and reported as calibrating; afterwards the excess over the baseline is
// checked against loud_margin and noise_margin, and a saturating run of loud
// samples longer than jam_run_limit reports jamming. Transactions are worked
// one at a time: a calibrating sample occupies the block from acceptance to
// the next ready through decide, a wait on the bit-serial divider that forms
// the running mean, the baseline write and the result load, a detection sample
// through decide and the result load. The result sits in an output register,
// so a new request is taken while an earlier result is still waiting; the
// result load waits only while that register is still full and not taken on
// the rsp side. Registers are to be written through the csr port only while
// the block is idle; keeping to this is up to the user, as the block has no
// check for it.
// ----------------------------------------------------------------------------
module rssi_jamming_detector (
   input  logic                               clock,
   input  logic                               reset,
   rjd_req_if.sink                            req_bus,
   rjd_rsp_if.source                          rsp_bus,
   input  logic                               csr_write_enable,
   input  logic [rjd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rjd_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import rjd_pkg::*;

   // configuration registers
   cfg_type     cfg_ff, cfg_in;

   // controller and datapath handshake
   dp_cmd_type  cmd;
   dp_stat_type stat;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_WARMUP_SAMPLES: cfg_in.warmup_samples = csr_write_data[WARM_W-1:0];
            CSR_LOUD_MARGIN:    cfg_in.loud_margin    = csr_write_data[MARGIN_W-1:0];
            CSR_NOISE_MARGIN:   cfg_in.noise_margin   = csr_write_data[MARGIN_W-1:0];
            CSR_JAM_RUN_LIMIT:  cfg_in.jam_run_limit  = csr_write_data[RUN_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.warmup_samples <= WARMUP_RESET;
         cfg_ff.loud_margin    <= LOUD_RESET;
         cfg_ff.noise_margin   <= NOISE_RESET;
         cfg_ff.jam_run_limit  <= RUN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sequencer: one transaction in flight, owns both valid/ready sides
   rjd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   // arithmetic, detector state and the result register
   rjd_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .cfg              (cfg_ff),
      .req_rssi_half_db (req_bus.rssi_half_db),
      .req_restart      (req_bus.restart),
      .rsp_status       (rsp_bus.status),
      .rsp_rssi_dbm     (rsp_bus.rssi_dbm),
      .rsp_baseline_dbm (rsp_bus.baseline_dbm),
      .rsp_bar_percent  (rsp_bus.bar_percent)
   );

endmodule

>>> rtl/core/rjd_checker.sv
// ----------------------------------------------------------------------------
// rjd_checker
// port-level assertions for the rssi jamming detector
// ----------------------------------------------------------------------------
`include "rssi_jamming_detector_macros.svh"

module rjd_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   // no result pending right after reset
   `RJD_ASSERT_ALWAYS(a_idle_after_reset, clock, reset |=> !rsp_valid, "rsp valid after reset")

   // a stalled result stays offered
   `RJD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp dropped")

   // one transaction at a time: busy right after acceptance
   `RJD_ASSERT(a_busy_after_req, clock, reset, req_valid && req_ready |=> !req_ready, "req reaccepted")

   // a new result only follows a cycle of work
   `RJD_ASSERT(a_rsp_after_work, clock, reset, $rose(rsp_valid) |-> !$past(req_ready), "rsp while idle")

endmodule

bind rssi_jamming_detector rjd_checker u_rjd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready)
);

>>> test/tb_rssi_jamming_detector.sv
// ----------------------------------------------------------------------------
// tb_rssi_jamming_detector
// Self-checking bench for the rssi jamming detector. A scoreboard class keeps
// its own copy of the calibration state and registers, predicts every verdict
// when a sample transaction is accepted, and compares each response
// transaction field by field. Stimulus is a directed pass over boundaries and
// special cases, a long loud run, then random phases under random settings.
// ----------------------------------------------------------------------------
module tb_rssi_jamming_detector;
   timeunit 1ns;
   timeprecision 1ps;

   import rjd_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transaction
   localparam int SAMPLE_TARGET  = 1400;  // samples before the random part stops
   localparam int DRAIN_CYCLES   = 30;    // a bit over one calibration step

   // one expected verdict as it appears on the rsp channel
   typedef struct {
      status_type                status;
      logic signed [DBM_W-1:0]   rssi_dbm;
      logic signed [DBM_W-1:0]   baseline_dbm;
      logic [BAR_W-1:0]          bar_percent;
   } verdict_type;

   // -------------------------------------------------------------------------
   // scoreboard: tracks baseline and loud run, queues predicted verdicts
   // -------------------------------------------------------------------------
   class verdict_board_type;
      cfg_type                  settings;
      logic [WARM_W-1:0]        warm_count;
      logic signed [SUM_W-1:0]  warm_sum;
      logic signed [BASE_W-1:0] baseline;
      logic [RUN_W-1:0]         loud_run;
      verdict_type              pending_verdicts[$];
      int                       mismatches;
      int                       checked;

      function new();
         settings.warmup_samples = WARMUP_RESET;
         settings.loud_margin    = LOUD_RESET;
         settings.noise_margin   = NOISE_RESET;
         settings.jam_run_limit  = RUN_RESET;
         warm_count = '0;
         warm_sum   = '0;
         baseline   = '0;
         loud_run   = '0;
         mismatches = 0;
         checked    = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_WARMUP_SAMPLES: settings.warmup_samples = value[WARM_W-1:0];
            CSR_LOUD_MARGIN:    settings.loud_margin    = value[MARGIN_W-1:0];
            CSR_NOISE_MARGIN:   settings.noise_margin   = value[MARGIN_W-1:0];
            CSR_JAM_RUN_LIMIT:  settings.jam_run_limit  = value[RUN_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending_count();
         return pending_verdicts.size();
      endfunction

      // an accepted sample: update state, queue the verdict it causes
      function void take_sample(logic signed [RSSI_W-1:0] x, logic restart);
         int          excess;
         int          scaled;
         int          bar;
         verdict_type v;

         if (restart) begin
            warm_count = '0;
            warm_sum   = '0;
            baseline   = '0;
            loud_run   = '0;
         end

         if (warm_count < settings.warmup_samples) begin
            // running mean, 4 fraction bits, truncated toward zero
            warm_sum   = warm_sum + x;
            warm_count = warm_count + 1'b1;
            baseline   = BASE_W'((int'(warm_sum) * 16) / int'(warm_count));
            loud_run   = '0;
            v.status   = STATUS_CALIBRATING;
         end else begin
            excess = int'(x) * 16 - int'(baseline);
            if (excess > int'(settings.loud_margin) * 16) begin
               if (loud_run != {RUN_W{1'b1}})
                  loud_run = loud_run + 1'b1;
            end else begin
               loud_run = '0;
            end
            if (loud_run > settings.jam_run_limit)
               v.status = STATUS_JAMMING;
            else if (excess > int'(settings.noise_margin) * 16)
               v.status = STATUS_NOISE;
            else
               v.status = STATUS_QUIET;
         end

         scaled = (int'(x) + 240) * 5;
         if (scaled < 16)
            bar = 2;
         else if (scaled / 8 > 100)
            bar = 100;
         else
            bar = scaled / 8;

         v.rssi_dbm     = DBM_W'(int'(x) / 2);
         v.baseline_dbm = DBM_W'(int'(baseline) / 32);
         v.bar_percent  = BAR_W'(bar);
         pending_verdicts.push_back(v);
      endfunction

      function void check_verdict(status_type status, logic signed [DBM_W-1:0] rssi_dbm,
                                  logic signed [DBM_W-1:0] baseline_dbm,
                                  logic [BAR_W-1:0] bar_percent);
         verdict_type want;
         if (pending_verdicts.size() == 0) begin
            $error("response transaction with no sample pending");
            mismatches++;
            return;
         end
         want = pending_verdicts.pop_front();
         checked++;
         if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            mismatches++;
         end
         if (rssi_dbm !== want.rssi_dbm) begin
            $error("rssi_dbm: expected %0d, actual %0d", want.rssi_dbm, rssi_dbm);
            mismatches++;
         end
         if (baseline_dbm !== want.baseline_dbm) begin
            $error("baseline_dbm: expected %0d, actual %0d", want.baseline_dbm, baseline_dbm);
            mismatches++;
         end
         if (bar_percent !== want.bar_percent) begin
            $error("bar_percent: expected %0d, actual %0d", want.bar_percent, bar_percent);
            mismatches++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // clock, reset, channels and the block
   // -------------------------------------------------------------------------
   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   rjd_req_if req_bus();
   rjd_rsp_if rsp_bus();

   verdict_board_type board;

   // run statistics for the closing summary
   int  samples_sent     = 0;
   int  restarts_sent    = 0;
   int  settings_applied = 0;
   int  quiet_cycles     = 0;
   // while set, neither side inserts gaps
   logic steady;

   rssi_jamming_detector dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // toggle stretches with no idling at all on either side
   initial begin
      steady = 1'b0;
      forever begin
         repeat ($urandom_range(100, 600)) @(posedge clock);
         steady <= ($urandom_range(0, 3) == 0);
      end
   end

   // gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady)
         return 0;
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // -------------------------------------------------------------------------
   // driver tasks
   // -------------------------------------------------------------------------

   // one sample transaction; valid stays high between back-to-back samples,
   // and a gap lowers it first
   task automatic send_sample(input int value, input logic restart);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.rssi_half_db <= RSSI_W'(value);
      req_bus.restart      <= restart;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      // accepted at this edge
      board.take_sample(RSSI_W'(value), restart);
      samples_sent++;
      if (restart)
         restarts_sent++;
   endtask

   // stop sending and wait for every verdict to come back
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (board.pending_count() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input int value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= CSR_DATA_W'(value);
      @(posedge clock);
      board.write_register(idx, CSR_DATA_W'(value));
   endtask

   // all four registers, one write per cycle; only called while idle
   task automatic apply_settings(input int warmup, input int loud, input int noise,
                                 input int run_limit);
      write_register(CSR_WARMUP_SAMPLES, warmup);
      write_register(CSR_LOUD_MARGIN, loud);
      write_register(CSR_NOISE_MARGIN, noise);
      write_register(CSR_JAM_RUN_LIMIT, run_limit);
      csr_write_enable <= 1'b0;
      settings_applied++;
   endtask

   // random settings, then calibration followed by quiet stretches,
   // loud bursts and the odd wild sample or mid-run restart
   task automatic run_random_phase();
      int   warmup;
      int   loud;
      int   noise;
      int   run_limit;
      int   level;
      int   count;
      int   burst_left;
      int   value;
      int   r;
      int   i;
      logic restart;

      r = $urandom_range(0, 99);
      if (r < 10)      warmup = 63;
      else if (r < 18) warmup = 0;
      else if (r < 28) warmup = $urandom_range(9, 62);
      else             warmup = $urandom_range(1, 8);

      r = $urandom_range(0, 99);
      if (r < 12)      loud = 0;
      else if (r < 20) loud = 255;
      else if (r < 30) loud = $urandom_range(41, 254);
      else             loud = $urandom_range(4, 40);

      r = $urandom_range(0, 99);
      if (r < 12)      noise = 0;
      else if (r < 18) noise = 255;
      else if (r < 28) noise = $urandom_range(41, 254);
      else             noise = $urandom_range(2, 40);

      r = $urandom_range(0, 99);
      if (r < 10)      run_limit = 254;
      else if (r < 18) run_limit = 255;
      else if (r < 30) run_limit = $urandom_range(7, 40);
      else             run_limit = $urandom_range(0, 6);

      settle();
      apply_settings(warmup, loud, noise, run_limit);

      // a phase without restart keeps the calibration as it stands
      restart    = ($urandom_range(0, 99) < 80);
      level      = int'($urandom_range(0, 156)) - 256;
      count      = $urandom_range(20, 60);
      burst_left = 0;

      for (i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 4) begin
            // any 9-bit pattern, positive samples included
            value = int'($signed(RSSI_W'($urandom)));
         end else if (burst_left > 0) begin
            value = level + loud + int'($urandom_range(0, 24));
            burst_left--;
         end else if (r < 16) begin
            burst_left = $urandom_range(1, (run_limit < 40) ? run_limit + 4 : 40);
            value = level + loud + int'($urandom_range(0, 24));
         end else begin
            value = level - 6 + int'($urandom_range(0, noise + 12));
         end
         if (value > 255)
            value = 255;
         if (value < -256)
            value = -256;
         send_sample(value, (i == 0) ? restart : ($urandom_range(0, 99) < 3));
      end
   endtask

   // -------------------------------------------------------------------------
   // response side: random back-pressure, one stall decision per transaction
   // -------------------------------------------------------------------------
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   // verdicts are compared at the edge where they are taken
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         board.check_verdict(rsp_bus.status, rsp_bus.rssi_dbm, rsp_bus.baseline_dbm,
                             rsp_bus.bar_percent);
   end

   // watchdog: too long without any transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("** rssi_jamming_detector: FAILED **");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // main sequence
   // -------------------------------------------------------------------------
   initial begin
      board = new();
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.rssi_half_db <= '0;
      req_bus.restart      <= 1'b0;
      csr_write_enable     <= 1'b0;
      csr_index            <= CSR_WARMUP_SAMPLES;
      csr_write_data       <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // short warmup: baseline from the field extremes, -512/4 half-dB
      // gives -64 dBm; then margin edges and a loud run past a limit of 2
      apply_settings(4, 30, 16, 2);
      send_sample(-256, 1'b1);
      send_sample(0, 1'b0);
      send_sample(-255, 1'b0);          // odd negative, truncation toward zero
      send_sample(-1, 1'b0);
      send_sample(-112, 1'b0);          // excess equals noise margin: quiet
      send_sample(-111, 1'b0);          // just above: noise
      send_sample(-98, 1'b0);           // excess equals loud margin: not loud
      send_sample(-97, 1'b0);           // loud run starts
      send_sample(-97, 1'b0);
      send_sample(0, 1'b0);             // run exceeds limit: jamming
      send_sample(255, 1'b0);           // largest positive sample
      send_sample(-240, 1'b0);          // bar floor, run cleared
      send_sample(-237, 1'b0);          // bar below 16/5 steps, clamps to 2
      send_sample(-80, 1'b0);           // bar ceiling

      // no warmup: baseline stays zero, detection at once; limit 255 never jams
      settle();
      apply_settings(0, 0, 0, 255);
      send_sample(0, 1'b1);
      send_sample(1, 1'b0);
      send_sample(255, 1'b0);
      send_sample(-256, 1'b0);
      send_sample(-256, 1'b1);

      // long warmup cut short: lowering it below the count ends calibration
      settle();
      apply_settings(63, 255, 255, 0);
      send_sample(-200, 1'b1);
      send_sample(-150, 1'b0);
      send_sample(-100, 1'b0);
      send_sample(-50, 1'b0);
      send_sample(-1, 1'b0);
      settle();
      apply_settings(2, 255, 255, 0);
      send_sample(-50, 1'b0);
      send_sample(255, 1'b0);

      // loud run long enough to saturate the counter at its top
      settle();
      apply_settings(1, 0, 0, 254);
      send_sample(-256, 1'b1);
      repeat (270) send_sample(int'($urandom_range(0, 240)) - 240, 1'b0);
      send_sample(-256, 1'b0);

      while (samples_sent < SAMPLE_TARGET)
         run_random_phase();

      // drain, then give a stray extra verdict time to show up
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d samples (%0d with restart) under %0d register settings",
               samples_sent, restarts_sent, settings_applied);
      $display("%0d verdicts compared, %0d mismatches", board.checked, board.mismatches);
      if (board.mismatches == 0)
         $display("** rssi_jamming_detector: PASSED **");
      else
         $display("** rssi_jamming_detector: FAILED **");
      $finish;
   end

endmodule
